// File: design/rte_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit table engine package
// Shared widths, codes and types of the retransmit table engine.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACT_W  = 2;
    localparam int SEQ_W  = 16;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 3;
    localparam int TICK_W = 16;

    localparam logic [LEN_W-1:0]  MAX_CHUNK     = 7'd100;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd2;

    // Input action codes. Code 3 has no meaning and is ignored.
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_TX          = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RETX        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACK_OK      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_UNKNOWN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL        = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_WRAP,
        CELL_MARK
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     en;
    } t_cell_ctrl;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [TICK_W-1:0] stamp;
    } t_entry;

endpackage

// File: design/rte_if.sv
// ----------------------------------------------------------------------------
// Retransmit table engine channels
// Valid/ready channels for input items, result items and the timeout register.
// ----------------------------------------------------------------------------
interface rte_in_if;
    logic                     valid;
    logic                     ready;
    logic [rte_pkg::ACT_W-1:0] action;
    logic [rte_pkg::SEQ_W-1:0] ack_seq;
    logic [rte_pkg::TAG_W-1:0] payload_tag;
    logic [rte_pkg::LEN_W-1:0] payload_len;

    modport source(output valid, action, ack_seq, payload_tag, payload_len, input ready);
    modport sink(input valid, action, ack_seq, payload_tag, payload_len, output ready);
endinterface

interface rte_out_if;
    logic                      valid;
    logic                      ready;
    logic [rte_pkg::KIND_W-1:0] kind;
    logic [rte_pkg::SEQ_W-1:0]  seq;
    logic [rte_pkg::TAG_W-1:0]  out_tag;
    logic [rte_pkg::LEN_W-1:0]  out_len;
    logic                      last;

    modport source(output valid, kind, seq, out_tag, out_len, last, input ready);
    modport sink(input valid, kind, seq, out_tag, out_len, last, output ready);
endinterface

interface rte_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rte_pkg::TICK_W-1:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// File: design/retransmit_table_engine_unit.sv
// ----------------------------------------------------------------------------
// Retransmit table engine
// Sender-side table of unacknowledged chunks with ack matching and timeouts.
// ----------------------------------------------------------------------------
// Items enter on i_in (action, ack_seq, payload_tag, payload_len) and results
// leave on o_out (kind, seq, out_tag, out_len, last). The timeout register is
// written through i_cfg, which is always ready; write it only while idle.
// A send or an ack gives a single result (none for a zero-length send), which
// appears in the output register on the next cycle. Taking a tick also
// marks every due entry in parallel, and then the table rotates once through
// the chain of cells, one entry per cycle unless a due head entry is held by
// an output stall. Each due entry leaves as a retransmit while it passes the
// head of the chain; the last one carries the last flag. A tick with nothing
// due gives no result.
// The output side has one register. A new item is taken only while the
// engine is idle and that register is empty or being drained in the same
// cycle. When the receiver stalls, the rotation waits at the next due entry
// and the pending result holds its value.
// Reset clears the table count, the sequence and tick counters, and sets the
// timeout to 2 ticks. Entry contents are not cleared; only entries below the
// count are ever read.
// ----------------------------------------------------------------------------
module retransmit_table_engine_unit (
    input logic i_clk,
    input logic i_rst_n,
    rte_in_if.sink    i_in,
    rte_out_if.source o_out,
    rte_cfg_if.sink   i_cfg
);

    localparam int DEPTH = rte_pkg::TABLE_DEPTH;

    // Control registers.
    rte_pkg::t_state             r_state;
    rte_pkg::t_state             n_state;
    logic [rte_pkg::CNT_W-1:0]   r_count;
    logic [rte_pkg::CNT_W-1:0]   n_count;
    logic [rte_pkg::CNT_W-1:0]   r_steps;
    logic [rte_pkg::CNT_W-1:0]   n_steps;
    logic [rte_pkg::SEQ_W-1:0]   r_next_seq;
    logic [rte_pkg::SEQ_W-1:0]   n_next_seq;
    logic [rte_pkg::TICK_W-1:0]  r_now;
    logic [rte_pkg::TICK_W-1:0]  n_now;
    logic [rte_pkg::TICK_W-1:0]  r_timeout;

    // Output register.
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [rte_pkg::KIND_W-1:0]  r_out_kind;
    logic [rte_pkg::KIND_W-1:0]  n_out_kind;
    logic [rte_pkg::SEQ_W-1:0]   r_out_seq;
    logic [rte_pkg::SEQ_W-1:0]   n_out_seq;
    logic [rte_pkg::TAG_W-1:0]   r_out_tag;
    logic [rte_pkg::TAG_W-1:0]   n_out_tag;
    logic [rte_pkg::LEN_W-1:0]   r_out_len;
    logic [rte_pkg::LEN_W-1:0]   n_out_len;
    logic                        r_out_last;
    logic                        n_out_last;

    // Chain signals.
    rte_pkg::t_cell_ctrl         w_ctrl  [DEPTH];
    rte_pkg::t_entry             w_entry [DEPTH];
    rte_pkg::t_entry             w_next  [DEPTH];
    logic [DEPTH-1:0]            w_due;
    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0]            w_in_tab;
    logic [DEPTH-1:0]            w_first;
    logic [DEPTH:0]              w_pre;

    rte_pkg::t_entry             w_new;
    rte_pkg::t_entry             w_wrap;
    logic [rte_pkg::TICK_W-1:0]  w_now_next;
    logic [rte_pkg::LEN_W-1:0]   w_len_sat;
    logic [rte_pkg::TAG_W-1:0]   w_hit_tag;
    logic [rte_pkg::LEN_W-1:0]   w_hit_len;
    logic                        w_hit;
    logic                        w_out_free;
    logic                        w_acc;
    logic                        w_step_go;
    logic                        w_head_last;
    logic [rte_pkg::CNT_W-1:0]   w_tail;

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == rte_pkg::ST_IDLE) && w_out_free;
    assign w_acc       = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.seq     = r_out_seq;
    assign o_out.out_tag = r_out_tag;
    assign o_out.out_len = r_out_len;
    assign o_out.last    = r_out_last;

    // ------------------------------------------------------------------
    // Entry being appended, and the head entry as it rejoins at the tail.
    // ------------------------------------------------------------------
    assign w_len_sat  = (i_in.payload_len > rte_pkg::MAX_CHUNK) ? rte_pkg::MAX_CHUNK
                                                              : i_in.payload_len;
    assign w_now_next = r_now + rte_pkg::TICK_W'(1);

    always_comb begin
        w_new.seq   = r_next_seq;
        w_new.tag   = i_in.payload_tag;
        w_new.len   = w_len_sat;
        w_new.stamp = r_now;
    end

    // A due head entry is stamped with the current tick as it wraps around.
    always_comb begin
        w_wrap = w_entry[0];
        if (w_due[0]) begin
            w_wrap.stamp = r_now;
        end
    end

    // The head entry is the final retransmit when no other cell is still due.
    assign w_head_last = (w_due[DEPTH-1:1] == '0);
    assign w_step_go   = (r_steps != '0) && (!w_due[0] || w_out_free);
    assign w_tail      = r_count - rte_pkg::CNT_W'(1);

    // ------------------------------------------------------------------
    // Ack lookup: the first occupied cell whose sequence number matches.
    // The prefix flag runs down the chain; every cell at or after the hit
    // takes the entry of its neighbor, closing the gap.
    // ------------------------------------------------------------------
    always_comb begin
        w_pre[0]  = 1'b0;
        w_hit_tag = '0;
        w_hit_len = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_in_tab[i] = (rte_pkg::CNT_W'(i) < r_count);
            w_first[i]  = w_match[i] && w_in_tab[i] && !w_pre[i];
            w_pre[i+1]  = w_pre[i] || (w_match[i] && w_in_tab[i]);
            w_hit_tag   = w_hit_tag | (w_first[i] ? w_entry[i].tag : '0);
            w_hit_len   = w_hit_len | (w_first[i] ? w_entry[i].len : '0);
        end
    end
    assign w_hit = w_pre[DEPTH];

    // ------------------------------------------------------------------
    // The chain of cells.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NXT = (g + 1 < DEPTH) ? g + 1 : g;

        assign w_next[g] = w_entry[NXT];

        rte_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[g]),
            .i_new      (w_new),
            .i_next     (w_next[g]),
            .i_next_due (w_due[NXT]),
            .i_wrap     (w_wrap),
            .i_ack_seq  (i_in.ack_seq),
            .i_now_next (w_now_next),
            .i_timeout  (r_timeout),
            .o_entry    (w_entry[g]),
            .o_due      (w_due[g]),
            .o_match    (w_match[g])
        );
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rte_pkg::ST_IDLE: begin
                if (w_acc && (i_in.action == rte_pkg::ACT_TICK) && (r_count != '0)) begin
                    n_state = rte_pkg::ST_TICK;
                end
            end
            rte_pkg::ST_TICK: begin
                if ((r_steps == '0) || (w_step_go && (r_steps == rte_pkg::CNT_W'(1)))) begin
                    n_state = rte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rte_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath control and results.
    // ------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_steps     = r_steps;
        n_next_seq  = r_next_seq;
        n_now       = r_now;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_seq   = r_out_seq;
        n_out_tag   = r_out_tag;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        for (int i = 0; i < DEPTH; i++) begin
            w_ctrl[i].op = rte_pkg::CELL_HOLD;
            w_ctrl[i].en = w_in_tab[i];
        end

        case (r_state)
            rte_pkg::ST_IDLE: begin
                if (w_acc) begin
                    case (i_in.action)
                        rte_pkg::ACT_SEND: begin
                            // A zero-length chunk is taken and dropped silently.
                            if (i_in.payload_len != '0) begin
                                n_out_valid = 1'b1;
                                n_out_seq   = r_next_seq;
                                n_out_tag   = i_in.payload_tag;
                                n_out_len   = w_len_sat;
                                n_out_last  = 1'b1;
                                if (r_count == rte_pkg::CNT_W'(DEPTH)) begin
                                    n_out_kind = rte_pkg::KIND_FULL;
                                end else begin
                                    n_out_kind = rte_pkg::KIND_TX;
                                    n_count    = r_count + rte_pkg::CNT_W'(1);
                                    n_next_seq = r_next_seq + rte_pkg::SEQ_W'(1);
                                    for (int i = 0; i < DEPTH; i++) begin
                                        if (rte_pkg::CNT_W'(i) == r_count) begin
                                            w_ctrl[i].op = rte_pkg::CELL_LOAD;
                                        end
                                    end
                                end
                            end
                        end
                        rte_pkg::ACT_ACK: begin
                            n_out_valid = 1'b1;
                            n_out_seq   = i_in.ack_seq;
                            n_out_last  = 1'b1;
                            if (w_hit) begin
                                n_out_kind = rte_pkg::KIND_ACK_OK;
                                n_out_tag  = w_hit_tag;
                                n_out_len  = w_hit_len;
                                n_count    = r_count - rte_pkg::CNT_W'(1);
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (w_pre[i+1]) begin
                                        w_ctrl[i].op = rte_pkg::CELL_SHIFT;
                                    end
                                end
                            end else begin
                                n_out_kind = rte_pkg::KIND_ACK_UNKNOWN;
                                n_out_tag  = '0;
                                n_out_len  = '0;
                            end
                        end
                        rte_pkg::ACT_TICK: begin
                            // Advance time and flag every entry that has aged out.
                            n_now   = w_now_next;
                            n_steps = r_count;
                            for (int i = 0; i < DEPTH; i++) begin
                                w_ctrl[i].op = rte_pkg::CELL_MARK;
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            rte_pkg::ST_TICK: begin
                if (w_step_go) begin
                    n_steps = r_steps - rte_pkg::CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (rte_pkg::CNT_W'(i) < w_tail) begin
                            w_ctrl[i].op = rte_pkg::CELL_SHIFT;
                        end else if (rte_pkg::CNT_W'(i) == w_tail) begin
                            w_ctrl[i].op = rte_pkg::CELL_WRAP;
                        end
                    end
                    if (w_due[0]) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = rte_pkg::KIND_RETX;
                        n_out_seq   = w_entry[0].seq;
                        n_out_tag   = w_entry[0].tag;
                        n_out_len   = w_entry[0].len;
                        n_out_last  = w_head_last;
                    end
                end
            end
            default: begin
                n_steps = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rte_pkg::ST_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_next_seq  <= '0;
            r_now       <= '0;
            r_timeout   <= rte_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_next_seq  <= n_next_seq;
            r_now       <= n_now;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_seq  <= n_out_seq;
        r_out_tag  <= n_out_tag;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The table never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rte_pkg::CNT_W'(DEPTH))
        else $error("table count exceeds depth");

    // Every rotation clears the due flags it has passed; none stay behind.
    a_idle_no_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rte_pkg::ST_IDLE) |-> (w_due == '0))
        else $error("due flag left set while idle");

    // The count moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_count == $past(r_count))
                         || (r_count == $past(r_count) + rte_pkg::CNT_W'(1))
                         || (r_count == $past(r_count) - rte_pkg::CNT_W'(1))))
        else $error("table count jumped");

    // A tick taken with a nonempty table starts a rotation.
    a_tick_rotates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.action == rte_pkg::ACT_TICK) && (r_count != '0))
            |=> ((r_state == rte_pkg::ST_TICK) && (r_steps == r_count)))
        else $error("tick did not start a rotation");

endmodule

// File: design/rte_cell.sv
// ----------------------------------------------------------------------------
// Retransmit table cell
// Holds one table entry and its due flag; loads, shifts, wraps or marks on command.
// ----------------------------------------------------------------------------
module rte_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rte_pkg::t_cell_ctrl        i_ctrl,
    input  rte_pkg::t_entry            i_new,
    input  rte_pkg::t_entry            i_next,
    input  logic                       i_next_due,
    input  rte_pkg::t_entry            i_wrap,
    input  logic [rte_pkg::SEQ_W-1:0]  i_ack_seq,
    input  logic [rte_pkg::TICK_W-1:0] i_now_next,
    input  logic [rte_pkg::TICK_W-1:0] i_timeout,
    output rte_pkg::t_entry            o_entry,
    output logic                       o_due,
    output logic                       o_match
);

    rte_pkg::t_entry            r_entry;
    rte_pkg::t_entry            n_entry;
    logic                       r_due;
    logic                       n_due;
    logic [rte_pkg::TICK_W-1:0] w_age;

    assign w_age = i_now_next - r_entry.stamp;

    always_comb begin
        n_entry = r_entry;
        n_due   = r_due;
        case (i_ctrl.op)
            rte_pkg::CELL_LOAD: begin
                n_entry = i_new;
            end
            rte_pkg::CELL_SHIFT: begin
                n_entry = i_next;
                n_due   = i_next_due;
            end
            rte_pkg::CELL_WRAP: begin
                // The head entry has been handled; it rejoins at the tail.
                n_entry = i_wrap;
                n_due   = 1'b0;
            end
            rte_pkg::CELL_MARK: begin
                n_due = i_ctrl.en && (w_age >= i_timeout);
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_due <= 1'b0;
        end else begin
            r_due <= n_due;
        end
    end

    assign o_entry = r_entry;
    assign o_due   = r_due;
    assign o_match = (r_entry.seq == i_ack_seq);

endmodule
